[rtl/dsf_pkg.sv]
// dsf_pkg: shared types and constants for the two-channel sound sample fifo
// no dependencies

package dsf_pkg;

  localparam int WORD_W         = 32;
  localparam int SAMPLE_W       = 8;
  localparam int FILL_OUT_W     = 3;
  localparam int PEND_W         = 3;
  localparam int BYTES_PER_WORD = 4;
  localparam int DMA_FREE_MIN   = 4;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_RESET = 2'd2
  } op_e;

  typedef enum logic {
    CFG_ARMED_A = 1'b0,
    CFG_ARMED_B = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic              channel;
    logic [WORD_W-1:0] word;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       dma_request;
    logic [FILL_OUT_W-1:0]      fill_level;
    logic [WORD_W-1:0]          next_slot_word;
  } result_t;

endpackage

[rtl/dsf_in_if.sv]
// dsf_in_if: input channel, valid/ready with one command item
// depends on dsf_pkg

interface dsf_in_if import dsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic              channel;
  logic [WORD_W-1:0] word;

  modport source (output valid, operation, channel, word, input ready);
  modport sink   (input valid, operation, channel, word, output ready);
endinterface

[rtl/dsf_out_if.sv]
// dsf_out_if: result channel, valid/ready with one result item
// depends on dsf_pkg

interface dsf_out_if import dsf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       dma_request;
  logic [FILL_OUT_W-1:0]      fill_level;
  logic [WORD_W-1:0]          next_slot_word;

  modport source (output valid, sample, dma_request, fill_level, next_slot_word, input ready);
  modport sink   (input valid, sample, dma_request, fill_level, next_slot_word, output ready);
endinterface

[rtl/dsf_ring_mem.sv]
// dsf_ring_mem: word ring storage for both channels, one write and one read port
// registered read data, per-entry valid bits so unwritten entries read as zero; uses dsf_pkg

module dsf_ring_mem import dsf_pkg::*; #(
  parameter int ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  localparam int ENTRIES = 1 << ADDR_W;

  logic [WORD_W-1:0]  mem [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [WORD_W-1:0]  rdata_q;
  logic               rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

[rtl/dsf_chan_ctrl.sv]
// dsf_chan_ctrl: per-channel pointers, shift word and pending count
// issues ring accesses at accept, applies the item on commit; uses dsf_pkg

module dsf_chan_ctrl import dsf_pkg::*; #(
  parameter int FIFO_DEPTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              acc_i,
  input  item_t                             in_item_i,
  input  item_t                             item_q_i,
  input  logic                              commit_i,
  input  logic [WORD_W-1:0]                 rdata_i,
  input  logic [1:0]                        armed_i,
  output logic                              mem_we_o,
  output logic [$clog2(FIFO_DEPTH):0]       mem_waddr_o,
  output logic [WORD_W-1:0]                 mem_wdata_o,
  output logic                              mem_re_o,
  output logic [$clog2(FIFO_DEPTH):0]       mem_raddr_o,
  output result_t                           result_o
);

  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

  logic [PTR_W-1:0]  wptr_q  [2];
  logic [PTR_W-1:0]  rptr_q  [2];
  logic [WORD_W-1:0] shift_q [2];
  logic [PEND_W-1:0] pend_q  [2];

  logic [PTR_W-1:0]  wptr_d, rptr_d;
  logic [WORD_W-1:0] shift_d;
  logic [PEND_W-1:0] pend_d;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // ring access for the item being accepted
  logic             in_ch;
  logic [PTR_W-1:0] in_wp;

  always_comb begin
    in_ch       = in_item_i.channel;
    in_wp       = wptr_q[in_ch];
    mem_re_o    = acc_i;
    mem_we_o    = acc_i && (in_item_i.operation == OP_WRITE);
    mem_waddr_o = {in_ch, in_wp};
    mem_wdata_o = in_item_i.word;
    if (in_item_i.operation == OP_WRITE) begin
      mem_raddr_o = {in_ch, next_ptr(in_wp)};
    end else begin
      mem_raddr_o = {in_ch, rptr_q[in_ch]};
    end
  end

  // item execution once the read data is back
  logic              ch;
  logic [PTR_W-1:0]  w, r;
  logic [FILL_W-1:0] fill;
  logic              load;
  logic [WORD_W-1:0] cur;
  logic [PEND_W-1:0] pend_eff;

  always_comb begin
    ch       = item_q_i.channel;
    w        = wptr_q[ch];
    r        = rptr_q[ch];
    if (w >= r) begin
      fill = FILL_W'(w) - FILL_W'(r);
    end else begin
      fill = FILL_W'(FIFO_DEPTH) - FILL_W'(r) + FILL_W'(w);
    end
    load     = (pend_q[ch] == '0) && (fill != '0);
    cur      = load ? rdata_i : shift_q[ch];
    pend_eff = load ? PEND_W'(BYTES_PER_WORD) : pend_q[ch];

    wptr_d   = w;
    rptr_d   = r;
    shift_d  = shift_q[ch];
    pend_d   = pend_q[ch];
    result_o = '0;

    case (op_e'(item_q_i.operation))
      OP_WRITE: begin
        wptr_d                  = next_ptr(w);
        result_o.next_slot_word = rdata_i;
      end
      OP_TICK: begin
        result_o.dma_request = (fill < FILL_W'(FIFO_DEPTH - DMA_FREE_MIN)) && armed_i[ch];
        result_o.fill_level  = fill[FILL_OUT_W-1:0];
        result_o.sample      = cur[SAMPLE_W-1:0];
        if (load) begin
          rptr_d = next_ptr(r);
        end
        if (pend_eff != '0) begin
          shift_d = {{SAMPLE_W{cur[WORD_W-1]}}, cur[WORD_W-1:SAMPLE_W]};
          pend_d  = pend_eff - 1'b1;
        end else begin
          shift_d = cur;
          pend_d  = pend_eff;
        end
      end
      OP_RESET: begin
        wptr_d = '0;
        rptr_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '{default: '0};
      rptr_q  <= '{default: '0};
      shift_q <= '{default: '0};
      pend_q  <= '{default: '0};
    end else if (commit_i) begin
      wptr_q[ch]  <= wptr_d;
      rptr_q[ch]  <= rptr_d;
      shift_q[ch] <= shift_d;
      pend_q[ch]  <= pend_d;
    end
  end

endmodule

[rtl/dma_sound_fifo_channel.sv]
// dma_sound_fifo_channel: two-channel 8-bit sound sample fifo fed by word writes
// depends on dsf_pkg, dsf_in_if, dsf_out_if, dsf_ring_mem, dsf_chan_ctrl
//
//   port     | dir | content
//   ---------+-----+----------------------------------------------
//   in_i     | in  | operation, channel, word (valid/ready)
//   out_o    | out | sample, dma_request, fill_level, next_slot_word
//   cfg_*_i  | in  | write enable, register index, 1-bit data
//
// each item goes through the ring read issued at accept, then the
// update and result when the read data returns
// a finished result waits in the output register while the next item is accepted
// a stalled output holds the item in execution until the register frees up
// reset clears pointers, shift words and entry valid bits at once, no sweep

module dma_sound_fifo_channel import dsf_pkg::*; #(
  parameter int FIFO_DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  dsf_in_if.sink           in_i,
  dsf_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic             cfg_data_i
);

  localparam int ADDR_W = $clog2(FIFO_DEPTH) + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e  state_q;
  item_t   item_q, in_item;
  result_t result, out_q;
  logic    out_valid_q;
  logic [1:0] armed_q;
  logic    acc, commit;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  assign in_i.ready = (state_q == S_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign commit     = (state_q == S_EXEC) && (!out_valid_q || out_o.ready);

  assign in_item.operation = in_i.operation;
  assign in_item.channel   = in_i.channel;
  assign in_item.word      = in_i.word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 2'b11;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ARMED_A: armed_q[0] <= cfg_data_i;
        CFG_ARMED_B: armed_q[1] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      item_q <= in_item;
    end
    if (commit) begin
      out_q <= result;
    end
  end

  dsf_ring_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dsf_chan_ctrl #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .in_item_i   (in_item),
    .item_q_i    (item_q),
    .commit_i    (commit),
    .rdata_i     (mem_rdata),
    .armed_i     (armed_q),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .result_o    (result)
  );

  assign out_o.valid          = out_valid_q;
  assign out_o.sample         = out_q.sample;
  assign out_o.dma_request    = out_q.dma_request;
  assign out_o.fill_level     = out_q.fill_level;
  assign out_o.next_slot_word = out_q.next_slot_word;

endmodule

[rtl/dsf_checker.sv]
// dsf_checker: port-level checks for dma_sound_fifo_channel, attached by bind
// depends on dsf_pkg

module dsf_checker import dsf_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic signed [SAMPLE_W-1:0] sample_i,
  input logic                       dma_request_i,
  input logic [FILL_OUT_W-1:0]      fill_level_i,
  input logic [WORD_W-1:0]          next_slot_word_i
);

  // one item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted while previous item still executing");

  // with room at the output at accept, the result commits from S_EXEC and then shows as valid
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (!out_valid_i || out_ready_i) |=> ##1 out_valid_i)
    else $error("result missing two cycles after accept");

  // write results carry only the slot word
  a_write_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (next_slot_word_i != '0) |->
      (sample_i == '0) && !dma_request_i && (fill_level_i == '0))
    else $error("write result mixed with tick fields");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sample_i) &&
      $stable(dma_request_i) && $stable(fill_level_i) && $stable(next_slot_word_i))
    else $error("stalled result changed");

endmodule

bind dma_sound_fifo_channel dsf_checker u_dsf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .sample_i         (out_o.sample),
  .dma_request_i    (out_o.dma_request),
  .fill_level_i     (out_o.fill_level),
  .next_slot_word_i (out_o.next_slot_word)
);

[dv/tb.sv]
// tb: self-checking bench for dma_sound_fifo_channel, directed table then random phases
// depends on dsf_pkg, dsf_in_if, dsf_out_if and the rtl top level
// results are checked in order against a cycle-free model of both sound channels

module tb import dsf_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 8;
  localparam int LIMIT       = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 120;
  localparam int N_PLAN      = 25;
  localparam int MAX_LINES   = 100;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic              ch;
    logic [WORD_W-1:0] word;
    logic              typed;
    result_t           res;
  } row_t;

  localparam result_t NO_RESULT = '0;
  localparam result_t IDLE_TICK = '{sample: '0, dma_request: 1'b1, fill_level: '0,
                                    next_slot_word: '0};

  localparam row_t PLAN [N_PLAN] = '{
    '{OP_TICK,   1'b0, 32'h0000_0000, 1'b1, IDLE_TICK},
    '{OP_TICK,   1'b1, 32'h0000_0000, 1'b1, IDLE_TICK},
    '{OP_UNUSED, 1'b0, 32'hFFFF_FFFF, 1'b1, NO_RESULT},
    '{OP_UNUSED, 1'b1, 32'h0000_0000, 1'b1, NO_RESULT},
    '{OP_WRITE,  1'b0, 32'h80FF_7F01, 1'b1, NO_RESULT},
    '{OP_WRITE,  1'b0, 32'hFFFF_FFFF, 1'b1, NO_RESULT},
    '{OP_TICK,   1'b0, 32'h0000_0000, 1'b0, NO_RESULT},
    '{OP_TICK,   1'b0, 32'h0000_0000, 1'b0, NO_RESULT},
    '{OP_TICK,   1'b0, 32'h0000_0000, 1'b0, NO_RESULT},
    '{OP_TICK,   1'b0, 32'h0000_0000, 1'b0, NO_RESULT},
    '{OP_TICK,   1'b0, 32'h0000_0000, 1'b0, NO_RESULT},
    '{OP_RESET,  1'b0, 32'h0000_0000, 1'b1, NO_RESULT},
    '{OP_TICK,   1'b0, 32'h0000_0000, 1'b0, NO_RESULT},
    '{OP_WRITE,  1'b1, 32'h7F00_0080, 1'b0, NO_RESULT},
    '{OP_WRITE,  1'b1, 32'h8000_0000, 1'b0, NO_RESULT},
    '{OP_WRITE,  1'b1, 32'h7FFF_FFFF, 1'b0, NO_RESULT},
    '{OP_WRITE,  1'b1, 32'h0000_0000, 1'b0, NO_RESULT},
    '{OP_WRITE,  1'b1, 32'hA5A5_5A5A, 1'b0, NO_RESULT},
    '{OP_WRITE,  1'b1, 32'h1234_5678, 1'b0, NO_RESULT},
    '{OP_WRITE,  1'b1, 32'hFEDC_BA98, 1'b0, NO_RESULT},
    '{OP_WRITE,  1'b1, 32'h0000_00FF, 1'b0, NO_RESULT},
    '{OP_TICK,   1'b1, 32'h0000_0000, 1'b0, NO_RESULT},
    '{OP_WRITE,  1'b1, 32'h5A5A_0000, 1'b0, NO_RESULT},
    '{OP_TICK,   1'b1, 32'h0000_0000, 1'b0, NO_RESULT},
    '{OP_RESET,  1'b1, 32'h0000_0000, 1'b1, NO_RESULT}
  };

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we;
  cfg_idx_e cfg_idx;
  logic     cfg_data;

  dsf_in_if  in_if ();
  dsf_out_if out_if ();

  dma_sound_fifo_channel u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // channel state as the block should hold it
  logic [WORD_W-1:0] ring_m [2][DEPTH];
  int unsigned       wr_m [2];
  int unsigned       rd_m [2];
  int unsigned       pend_m [2];
  logic [WORD_W-1:0] shift_m [2];
  logic              arm_m [2];

  result_t due_results [$];
  int      errors;
  int      cycles;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_token;

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (errors < MAX_LINES) $display("[%0d] mismatch: %s", cycles, what);
    errors++;
  endtask

  function automatic result_t predict_sound(input item_t it);
    result_t     r;
    int unsigned c;
    int unsigned fill;
    r = '0;
    c = it.channel;
    case (it.operation)
      OP_WRITE: begin
        ring_m[c][wr_m[c]] = it.word;
        wr_m[c] = (wr_m[c] + 1) % DEPTH;
        r.next_slot_word = ring_m[c][wr_m[c]];
      end
      OP_TICK: begin
        fill = (wr_m[c] >= rd_m[c]) ? wr_m[c] - rd_m[c] : DEPTH - rd_m[c] + wr_m[c];
        r.dma_request = (DEPTH - fill > DMA_FREE_MIN) && arm_m[c];
        if (pend_m[c] == 0 && fill != 0) begin
          shift_m[c] = ring_m[c][rd_m[c]];
          pend_m[c] = BYTES_PER_WORD;
          rd_m[c] = (rd_m[c] + 1) % DEPTH;
        end
        r.sample = shift_m[c][SAMPLE_W-1:0];
        if (pend_m[c] != 0) begin
          shift_m[c] = $signed(shift_m[c]) >>> SAMPLE_W;
          pend_m[c]--;
        end
        r.fill_level = FILL_OUT_W'(fill);
      end
      OP_RESET: begin
        wr_m[c] = 0;
        rd_m[c] = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // valid stays high across back-to-back items, it is only lowered for a gap
  task automatic send_item(input item_t it, input logic typed, input result_t fixed);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= it.operation;
    in_if.channel   <= it.channel;
    in_if.word      <= it.word;
    do @(posedge clk_i); while (!in_if.ready);
    r = predict_sound(it);
    due_results.push_back(typed ? fixed : r);
  endtask

  task automatic finish_phase();
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    arm_m[idx] = value;
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver, with a long hold-off whenever the token moves
  initial begin
    int seen;
    int hold_left;
    out_if.ready = 1'b0;
    seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_token != seen) begin
        seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.sample, out_if.dma_request, out_if.fill_level, out_if.next_slot_word};
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
      end else begin
        want = due_results.pop_front();
        if (got.sample !== want.sample || got.dma_request !== want.dma_request ||
            got.fill_level !== want.fill_level ||
            got.next_slot_word !== want.next_slot_word) begin
          report_mismatch($sformatf("sample %0d/%0d req %0b/%0b fill %0d/%0d slot %h/%h",
                                    want.sample, got.sample, want.dma_request,
                                    got.dma_request, want.fill_level, got.fill_level,
                                    want.next_slot_word, got.next_slot_word));
        end
      end
    end
  end

  initial begin
    item_t it;
    int    write_bias;
    int    roll;
    in_if.valid     = 1'b0;
    in_if.operation = OP_WRITE;
    in_if.channel   = 1'b0;
    in_if.word      = '0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_ARMED_A;
    cfg_data        = 1'b0;
    rst_ni          = 1'b0;
    errors          = 0;
    cycles          = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_token      = 0;
    write_bias      = 50;
    for (int c = 0; c < 2; c++) begin
      for (int k = 0; k < DEPTH; k++) ring_m[c][k] = '0;
      wr_m[c] = 0;
      rd_m[c] = 0;
      pend_m[c] = 0;
      shift_m[c] = '0;
      arm_m[c] = 1'b1;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_PLAN; i++) begin
      it.operation = PLAN[i].op;
      it.channel   = PLAN[i].ch;
      it.word      = PLAN[i].word;
      send_item(it, PLAN[i].typed, PLAN[i].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      finish_phase();
      write_cfg(CFG_ARMED_A, ph[0]);
      write_cfg(CFG_ARMED_B, ph[1]);
      case (ph % 4)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= 79;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 79;
        end
        default: begin
          send_idle_pct  <= 20;
          recv_stall_pct <= 20;
        end
      endcase
      @(posedge clk_i);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == 10) hold_token <= hold_token + 1;
        // bursts lean toward writes or ticks so fill levels sweep the whole ring
        if (n % 16 == 0) write_bias = $urandom_range(85, 15);
        roll = $urandom_range(99);
        if (roll < 2) it.operation = OP_UNUSED;
        else if (roll < 5) it.operation = OP_RESET;
        else if ($urandom_range(99) < write_bias) it.operation = OP_WRITE;
        else it.operation = OP_TICK;
        it.channel = 1'($urandom_range(1));
        case ($urandom_range(7))
          0: it.word = '0;
          1: it.word = '1;
          2: it.word = 32'h8000_0000;
          3: it.word = 32'h7FFF_FFFF;
          default: it.word = $urandom;
        endcase
        send_item(it, 1'b0, NO_RESULT);
      end
    end

    finish_phase();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
